/* rtl/core/sbst_pkg.sv */
// Shared types and constants of the sparse brick slot table.
package sbst_pkg;

    // Field widths of the transfers
    localparam int POS_W      = 6;
    localparam int SLOT_W     = 6;
    localparam int ACTION_W   = 2;
    localparam int MAP_BITS   = 64;
    localparam int USED_W     = 7;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 88;

    // Action codes carried by the input transfer
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CREATE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_STAT,
        ST_SCAN,
        ST_MOVE
    } sbst_state_t;

endpackage

/* rtl/core/sparse_brick_slot_table.sv */
// Top level of the sparse brick slot table: sequencer, allocation mask and slot store.
//
// Maps the brick positions of one sector to dense storage slots held in a small
// RAM; the allocation mask in flip-flops marks which entries are valid, so reset
// needs no clearing pass. A lookup or lookup-with-create goes in order: the
// transfer is taken, then the slot store read returns and the result is loaded
// into the output register. A status result (empty delete mask, delete that
// leaves nothing, unused action) is loaded into the output register after the
// transfer is taken. A delete walks the positions through the single read port
// of the slot store: after the transfer is taken it skips each position without
// a survivor, one per cycle, up to the highest survivor, and for each survivor
// reads the old slot, then emits the move and writes the new slot. Each result
// waits while the result side holds m_tready low.
module sparse_brick_slot_table
    import sbst_pkg::*;
#(
    parameter int BRICKS_PER_SECTOR = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // action[1:0], brick_pos[7:2], delete_mask[71:8]
    // Result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // found[0], slot[6:1], move_from[12:7],
                                            // move_to[18:13], alloc_mask[82:19], zero[87:83]
    output logic                 m_tuser,   // is_move
    output logic                 m_tlast
);

    localparam int AW = (BRICKS_PER_SECTOR > 1) ? $clog2(BRICKS_PER_SECTOR) : 1;
    localparam logic [MAP_BITS-1:0] PosMask = (BRICKS_PER_SECTOR >= MAP_BITS) ? '1 :
        ((MAP_BITS'(1) << BRICKS_PER_SECTOR) - MAP_BITS'(1));
    localparam logic [USED_W-1:0] Bricks = USED_W'(BRICKS_PER_SECTOR);

    // Input field split
    logic [ACTION_W-1:0] in_action;
    logic [POS_W-1:0]    in_pos;
    logic [MAP_BITS-1:0] in_dmask;

    assign in_action = s_tdata[ACTION_W-1:0];
    assign in_pos    = s_tdata[ACTION_W+POS_W-1:ACTION_W];
    assign in_dmask  = s_tdata[ACTION_W+POS_W+MAP_BITS-1:ACTION_W+POS_W] & PosMask;

    // Control state
    sbst_state_t         state_reg, state_next;
    logic [ACTION_W-1:0] act_reg, act_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [MAP_BITS-1:0] rem_reg, rem_next;
    logic [MAP_BITS-1:0] alloc_reg, alloc_next;
    logic [USED_W-1:0]   used_reg, used_next;
    logic                out_valid_reg, out_valid_next;

    // Result payload
    logic                out_found_reg, out_found_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic                out_move_reg, out_move_next;
    logic [SLOT_W-1:0]   out_from_reg, out_from_next;
    logic [SLOT_W-1:0]   out_to_reg, out_to_next;
    logic [MAP_BITS-1:0] out_alloc_reg, out_alloc_next;
    logic                out_last_reg, out_last_next;
    logic                out_load;

    // Slot store port signals
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [SLOT_W-1:0] ram_wdata;
    logic [SLOT_W-1:0] ram_rdata;

    logic              accept;
    logic              out_free;
    logic              pos_in_range;
    logic [MAP_BITS-1:0] keep;

    assign accept       = s_tvalid && s_tready;
    assign out_free     = !out_valid_reg || m_tready;
    assign pos_in_range = {1'b0, pos_reg} < Bricks;
    assign keep         = alloc_reg & ~in_dmask;

    sbst_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (BRICKS_PER_SECTOR)
    ) u_slot_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (pos_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer: next state, store accesses and result assembly
    always_comb begin
        state_next     = state_reg;
        act_next       = act_reg;
        pos_next       = pos_reg;
        rem_next       = rem_reg;
        alloc_next     = alloc_reg;
        used_next      = used_reg;
        s_tready       = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = pos_reg[AW-1:0];
        ram_wdata      = used_reg[SLOT_W-1:0];
        out_load       = 1'b0;
        out_found_next = 1'b0;
        out_slot_next  = '0;
        out_move_next  = 1'b0;
        out_from_next  = '0;
        out_to_next    = '0;
        out_alloc_next = alloc_reg;
        out_last_next  = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    act_next = in_action;
                    pos_next = in_pos;
                    case (in_action)
                        ACT_LOOKUP, ACT_CREATE: begin
                            ram_re     = 1'b1;
                            ram_raddr  = in_pos[AW-1:0];
                            state_next = ST_LOOK;
                        end
                        ACT_DELETE: begin
                            if (in_dmask != '0) begin
                                alloc_next = keep;
                                rem_next   = keep;
                                used_next  = '0;
                                pos_next   = '0;
                                state_next = (keep != '0) ? ST_SCAN : ST_STAT;
                            end else begin
                                state_next = ST_STAT;
                            end
                        end
                        default: begin
                            state_next = ST_STAT;
                        end
                    endcase
                end
            end

            ST_LOOK: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (pos_in_range && alloc_reg[pos_reg]) begin
                        out_found_next = 1'b1;
                        out_slot_next  = ram_rdata;
                    end else if (act_reg == ACT_CREATE && pos_in_range
                                 && used_reg < Bricks) begin
                        // Hand the next free slot to the missing brick
                        out_found_next      = 1'b1;
                        out_slot_next       = used_reg[SLOT_W-1:0];
                        ram_we              = 1'b1;
                        alloc_next[pos_reg] = 1'b1;
                        used_next           = used_reg + USED_W'(1);
                    end
                    out_alloc_next = alloc_next;
                    state_next     = ST_IDLE;
                end
            end

            ST_STAT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN: begin
                // Read the old slot of a survivor, skip the other positions
                if (rem_reg[pos_reg]) begin
                    ram_re     = 1'b1;
                    state_next = ST_MOVE;
                end else begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end

            ST_MOVE: begin
                if (out_free) begin
                    out_load          = 1'b1;
                    out_move_next     = 1'b1;
                    out_from_next     = ram_rdata;
                    out_to_next       = used_reg[SLOT_W-1:0];
                    ram_we            = 1'b1;
                    rem_next[pos_reg] = 1'b0;
                    out_last_next     = (rem_next == '0);
                    used_next         = used_reg + USED_W'(1);
                    pos_next          = pos_reg + POS_W'(1);
                    state_next        = (rem_next == '0) ? ST_IDLE : ST_SCAN;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Output register: load a new transfer or drop the one taken
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            act_reg       <= ACT_LOOKUP;
            pos_reg       <= '0;
            rem_reg       <= '0;
            alloc_reg     <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            pos_reg       <= pos_next;
            rem_reg       <= rem_next;
            alloc_reg     <= alloc_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, held while the transfer waits
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_found_reg <= out_found_next;
            out_slot_reg  <= out_slot_next;
            out_move_reg  <= out_move_next;
            out_from_reg  <= out_from_next;
            out_to_reg    <= out_to_next;
            out_alloc_reg <= out_alloc_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_alloc_reg, out_to_reg, out_from_reg, out_slot_reg,
                       out_found_reg};
    assign m_tuser  = out_move_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // No brick is ever recorded beyond the sector
    assert property (@(posedge aclk) disable iff (!aresetn)
        (alloc_reg & ~PosMask) == '0)
        else $error("allocation mask holds a position beyond the sector");

    // The slot count never passes the sector size
    assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= Bricks)
        else $error("slot count exceeds sector size");

    // Between operations the slot count matches the allocation mask
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> used_reg == USED_W'($countones(alloc_reg)))
        else $error("slot count disagrees with allocation mask");

    // The final move of a delete returns the sequencer to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOVE && out_load && out_last_next) |=> state_reg == ST_IDLE)
        else $error("sequencer did not finish after the final move");
`endif

endmodule

/* rtl/core/sbst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sbst_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, and read port that holds its data when not enabled
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* bench/sparse_brick_slot_table_test.sv */
// Self-checking testbench of the sparse brick slot table.
`timescale 1ns / 100ps

module sparse_brick_slot_table_test;
    import sbst_pkg::*;

    localparam int BRICKS = 64;
    localparam logic [63:0] SECTOR_BITS = (BRICKS >= 64) ? '1 : ((64'd1 << BRICKS) - 64'd1);
    // Action code with no function: answered with a status transfer only
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    // Worst delete walk, plus margin
    localparam int TAIL_CYCLES = 2 * BRICKS + 8;

    typedef struct packed {
        logic                found;
        logic [SLOT_W-1:0]   slot;
        logic                is_move;
        logic [SLOT_W-1:0]   move_from;
        logic [SLOT_W-1:0]   move_to;
        logic [MAP_BITS-1:0] alloc_mask;
        logic                last;
    } brick_result_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // action, brick_pos, delete_mask
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // found, slot, move_from, move_to, alloc_mask, zero
    logic                 m_tuser;          // is_move
    logic                 m_tlast;

    // Predicted table contents: 0 = no brick, else slot + 1
    logic [USED_W-1:0] slot_of [BRICKS];
    logic [USED_W-1:0] slots_used;
    brick_result_t     pending_results[$];

    int mismatch_count = 0;
    bit send_gaps_on   = 1'b1;
    bit recv_stalls_on = 1'b1;

    sparse_brick_slot_table #(
        .BRICKS_PER_SECTOR (BRICKS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [63:0] occupied_mask();
        logic [63:0] m;
        m = '0;
        for (int p = 0; p < BRICKS; p++) begin
            if (slot_of[p] != '0) m[p] = 1'b1;
        end
        return m;
    endfunction

    // Update the predicted table and queue the transfers the action causes
    task automatic apply_to_table(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
                                  input logic [63:0] mask);
        brick_result_t     r;
        logic [63:0]       keep;
        logic [USED_W-1:0] prior [BRICKS];
        int                n;
        int                k;
        r = '0;
        r.last = 1'b1;
        if (act == ACT_LOOKUP || act == ACT_CREATE) begin
            if (int'(pos) < BRICKS) begin
                if (slot_of[pos] != '0) begin
                    r.found = 1'b1;
                    r.slot  = SLOT_W'(slot_of[pos] - 7'd1);
                end else if (act == ACT_CREATE && int'(slots_used) < BRICKS) begin
                    r.found = 1'b1;
                    r.slot  = slots_used[SLOT_W-1:0];
                    slots_used = slots_used + 7'd1;
                    slot_of[pos] = slots_used;
                end
            end
            r.alloc_mask = occupied_mask();
            pending_results.push_back(r);
        end else if (act == ACT_DELETE && (mask & SECTOR_BITS) != '0) begin
            // Drop the masked bricks, then renumber survivors in position order
            keep  = occupied_mask() & ~mask;
            prior = slot_of;
            n     = 0;
            for (int p = 0; p < BRICKS; p++) begin
                slot_of[p] = '0;
                if (keep[p]) begin
                    n++;
                    slot_of[p] = n[USED_W-1:0];
                end
            end
            slots_used = n[USED_W-1:0];
            if (n == 0) begin
                pending_results.push_back(r);
            end else begin
                k = 0;
                for (int p = 0; p < BRICKS; p++) begin
                    if (keep[p]) begin
                        r            = '0;
                        r.is_move    = 1'b1;
                        r.move_from  = SLOT_W'(prior[p] - 7'd1);
                        r.move_to    = SLOT_W'(slot_of[p] - 7'd1);
                        r.alloc_mask = keep;
                        r.last       = (k + 1 == n);
                        pending_results.push_back(r);
                        k++;
                    end
                end
            end
        end else begin
            // Empty mask or unused action: status only
            r.alloc_mask = occupied_mask();
            pending_results.push_back(r);
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("%0t mismatch in %s: got %h, want %h", $realtime, what, got, want);
    endtask

    // Present one transfer on the input channel, hold it until taken
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
                             input logic [63:0] mask);
        int gap;
        gap = send_gaps_on ? $urandom_range(0, 17) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {mask, pos, act};
        do @(posedge aclk); while (!s_tready);
        apply_to_table(act, pos, mask);
    endtask

    // Hold the input channel idle until every predicted transfer has come out
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic send_random_item(input int create_pct, input int lookup_pct,
                                    input bit wide_deletes);
        int                  r;
        logic [ACTION_W-1:0] act;
        logic [POS_W-1:0]    pos;
        logic [63:0]         mask;
        logic [63:0]         occ;
        occ  = occupied_mask();
        r    = $urandom_range(0, 99);
        pos  = POS_W'($urandom_range(0, 63));
        mask = {$urandom, $urandom};
        if (r < create_pct) begin
            act = ACT_CREATE;
            // Half the time aim at a free position
            if ($urandom_range(0, 1) == 1 && occ != '1) begin
                while (occ[pos]) pos = pos + 6'd1;
            end
        end else if (r < create_pct + lookup_pct) begin
            act = ACT_LOOKUP;
            // Half the time aim at a present brick
            if ($urandom_range(0, 1) == 1 && occ != '0) begin
                while (!occ[pos]) pos = pos + 6'd1;
            end
        end else if (r < 98) begin
            act = ACT_DELETE;
            case (wide_deletes ? $urandom_range(0, 5) : 1)
                0: ;
                1: mask = 64'd1 << pos;
                2: mask = mask & {$urandom, $urandom} & {$urandom, $urandom};
                3: mask = mask & ~occ;
                4: mask = '0;
                default: mask = '1;
            endcase
        end else begin
            act = ACT_UNUSED;
        end
        send_item(act, pos, mask);
    endtask

    // Lookups, unused action and deletes on an empty table
    task automatic test_empty_table();
        send_item(ACT_LOOKUP, 6'd0, '0);
        send_item(ACT_LOOKUP, 6'd63, '1);
        send_item(ACT_UNUSED, 6'd63, '1);
        send_item(ACT_DELETE, 6'd0, '0);
        send_item(ACT_DELETE, 6'd63, '1);
    endtask

    // Creates at the position extremes, repeat create, miss and hit lookups
    task automatic test_create_lookup();
        send_item(ACT_CREATE, 6'd63, '0);
        send_item(ACT_CREATE, 6'd0, '1);
        send_item(ACT_CREATE, 6'd21, '0);
        send_item(ACT_CREATE, 6'd63, '0);
        send_item(ACT_LOOKUP, 6'd0, '0);
        send_item(ACT_LOOKUP, 6'd42, '0);
        send_item(ACT_CREATE, 6'd42, '0);
    endtask

    // Compaction: real drop, drop of absent bricks, wipe, single survivor
    task automatic test_delete_compaction();
        send_item(ACT_DELETE, 6'd0, 64'h0000_0000_0000_0001);
        send_item(ACT_DELETE, 6'd0, 64'h4000_0000_0000_0020);
        send_item(ACT_DELETE, 6'd0, 64'h8000_0000_0000_0000);
        send_item(ACT_DELETE, 6'd0, '1);
        send_item(ACT_CREATE, 6'd1, '0);
        send_item(ACT_CREATE, 6'd9, '0);
        send_item(ACT_DELETE, 6'd0, ~64'h0000_0000_0000_0002);
        pause_until_drained();
    endtask

    // Mostly creates, then top the table up to full, create once more and delete single bricks
    task automatic test_fill_table();
        logic [63:0]      occ;
        logic [POS_W-1:0] pos;
        repeat (160) send_random_item(70, 22, 1'b0);
        occ = occupied_mask();
        while (occ != '1) begin
            pos = POS_W'($urandom_range(0, 63));
            while (occ[pos]) pos = pos + 6'd1;
            send_item(ACT_CREATE, pos, '0);
            occ = occupied_mask();
        end
        send_item(ACT_CREATE, 6'd17, '0);
        send_item(ACT_DELETE, 6'd0, 64'd1 << $urandom_range(0, 63));
        send_item(ACT_DELETE, 6'd0, 64'd1 << $urandom_range(0, 63));
        pause_until_drained();
    endtask

    // Mixed traffic with every kind of delete mask
    task automatic test_mixed_traffic();
        repeat (200) send_random_item(40, 40, 1'b1);
    endtask

    // Back-to-back traffic with no gaps on either side
    task automatic test_back_to_back();
        send_gaps_on   = 1'b0;
        recv_stalls_on = 1'b0;
        repeat (100) send_random_item(45, 40, 1'b1);
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
    endtask

    // Delete-heavy traffic against a stalling receiver only
    task automatic test_delete_heavy();
        send_gaps_on = 1'b0;
        repeat (40) send_random_item(30, 20, 1'b1);
        send_gaps_on = 1'b1;
    endtask

    // Check each result transfer and draw the stall before the next one
    initial begin
        brick_result_t want;
        int            stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("unexpected result", m_tdata[63:0], '0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata[0] !== want.found)
                        flag_mismatch("found", 64'(m_tdata[0]), 64'(want.found));
                    if (m_tdata[6:1] !== want.slot)
                        flag_mismatch("slot", 64'(m_tdata[6:1]), 64'(want.slot));
                    if (m_tuser !== want.is_move)
                        flag_mismatch("is_move", 64'(m_tuser), 64'(want.is_move));
                    if (m_tdata[12:7] !== want.move_from)
                        flag_mismatch("move_from", 64'(m_tdata[12:7]), 64'(want.move_from));
                    if (m_tdata[18:13] !== want.move_to)
                        flag_mismatch("move_to", 64'(m_tdata[18:13]), 64'(want.move_to));
                    if (m_tdata[82:19] !== want.alloc_mask)
                        flag_mismatch("alloc_mask", m_tdata[82:19], want.alloc_mask);
                    if (m_tlast !== want.last)
                        flag_mismatch("last", 64'(m_tlast), 64'(want.last));
                end
                stall = recv_stalls_on ? $urandom_range(0, 17) : 0;
            end
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Run the tests in turn
    initial begin
        for (int p = 0; p < BRICKS; p++) slot_of[p] = '0;
        slots_used = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_table();
        test_create_lookup();
        test_delete_compaction();
        test_fill_table();
        test_mixed_traffic();
        test_back_to_back();
        test_delete_heavy();

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
